[rtl/gregorian_date_add_days_defines.svh]
// Assertion macros for the date adder checker.
`ifndef GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define GDAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdad check failed");

// Next-cycle implication, gated by reset.
`define GDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdad check failed");

`endif

[rtl/gdad_pkg.sv]
// Types, constants and calendar functions shared by the date adder.
package gdad_pkg;

    // Input word: start date and signed offset.
    typedef struct packed {
        logic [15:0]        start_year;
        logic [3:0]         start_month;
        logic [4:0]         start_day;
        logic signed [15:0] days_to_add;
    } t_in;

    // Result word: new date and status.
    typedef struct packed {
        logic [15:0] result_year;
        logic [3:0]  result_month;
        logic [4:0]  result_day;
        logic [1:0]  error_code;
    } t_out;

    // Outcome of one walk step.
    typedef struct packed {
        logic        fits;
        logic        wrap;
        logic [15:0] nd_next;
        logic [3:0]  month_next;
    } t_step;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_MONTH = 2'd1;
    localparam logic [1:0] ERR_DAY   = 2'd2;
    localparam logic [1:0] ERR_YEAR  = 2'd3;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [15:0] YEAR_MAX  = 16'hFFFF;

    // floor(y / 400) = (y * RECIP_400) >> RECIP_SHIFT for any 16-bit y.
    localparam logic [16:0] RECIP_400   = 17'd83887;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [8:0]  CYCLE_LAST  = 9'd399;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Leap test on the year's position within the 400-year cycle.
    function automatic logic is_leap(input logic [8:0] r400);
        logic by4;
        logic century;
        by4     = (r400[1:0] == 2'd0);
        century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
        return (by4 && !century) || (r400 == 9'd0);
    endfunction

    // Days in a month; zero for a month code outside 1..12.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month < MONTH_JAN || month > MONTH_DEC) begin
            len = 5'd0;
        end else if (month == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = MONTH_LEN[month - MONTH_JAN];
        end
        return len;
    endfunction

endpackage

[rtl/gregorian_date_add_days.sv]
// Date adder: one result word per accepted start, data-dependent latency.
// Steps after accepting start: year mod 400 (S_DIV), date check (S_CHECK), then
// S_WALK over months crossed (up to about 1080); date errors end at S_CHECK.
// Throughput: one word at a time; busy stays high until the result is out.
// The walk runs through one shared compare/subtract unit, one month a cycle.
// Reset (synchronous, active low) returns to idle and drops the done strobe.
module gregorian_date_add_days import gdad_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_done,
    output t_out o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;

    logic [2:0]         r_state, n_state;
    logic [15:0]        r_year, n_year;
    logic [3:0]         r_month, n_month;
    logic [4:0]         r_day;
    logic signed [15:0] r_off;
    logic [15:0]        r_nd, n_nd;
    logic [8:0]         r_y400, n_y400;
    logic               r_done, n_done;
    t_out               r_res, n_res;

    logic        load;
    logic [8:0]  rem;
    logic [15:0] step_nd;
    logic        leap;
    t_step       step;
    logic [16:0] sum;

    assign load = start && (r_state == S_IDLE);
    assign leap = is_leap(r_y400);

    gdad_mod400 u_mod400 (
        .i_clk  (i_clk),
        .i_load (load),
        .i_year (i_in.start_year),
        .o_rem  (rem)
    );

    // Check phase feeds the start day; walk phase feeds the running count
    assign step_nd = (r_state == S_CHECK) ? {11'd0, r_day} : r_nd;

    gdad_step u_step (
        .i_nd    (step_nd),
        .i_month (r_month),
        .i_leap  (leap),
        .o_step  (step)
    );

    assign sum = {12'd0, r_day} + {r_off[15], r_off};

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_year  = r_year;
        n_month = r_month;
        n_nd    = r_nd;
        n_y400  = r_y400;
        n_done  = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_year  = i_in.start_year;
                    n_month = i_in.start_month;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_y400  = rem;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_res   = '0;
                if (r_month < MONTH_JAN || r_month > MONTH_DEC) begin
                    n_res.error_code = ERR_MONTH;
                end else if (r_day == 5'd0 || !step.fits) begin
                    n_res.error_code = ERR_DAY;
                end else if (sum[16] || sum == 17'd0) begin
                    n_res.error_code = ERR_DAY;
                end else begin
                    n_nd    = sum[15:0];
                    n_done  = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (step.fits) begin
                    n_res.result_year  = r_year;
                    n_res.result_month = r_month;
                    n_res.result_day   = r_nd[4:0];
                    n_res.error_code   = ERR_OK;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (step.wrap && r_year == YEAR_MAX) begin
                    n_res   = '0;
                    n_res.error_code = ERR_YEAR;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_nd    = step.nd_next;
                    n_month = step.month_next;
                    if (step.wrap) begin
                        n_year = r_year + 16'd1;
                        n_y400 = (r_y400 == CYCLE_LAST) ? 9'd0 : r_y400 + 9'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_year  <= n_year;
        r_month <= n_month;
        r_nd    <= n_nd;
        r_y400  <= n_y400;
        r_res   <= n_res;
        if (load) begin
            r_day <= i_in.start_day;
            r_off <= i_in.days_to_add;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[rtl/gdad_mod400.sv]
// Year modulo 400 by reciprocal multiply, one register stage.
module gdad_mod400 import gdad_pkg::*; (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [15:0] i_year,
    output logic [8:0]  o_rem
);

    logic [15:0] r_yr;
    logic [7:0]  r_q;
    logic [32:0] prod;
    logic [15:0] q400;

    assign prod = {17'd0, i_year} * {16'd0, RECIP_400};

    // Capture quotient and year on load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_yr <= i_year;
            r_q  <= prod[RECIP_SHIFT +: 8];
        end
    end

    // Remainder: q * 400 = q*256 + q*128 + q*16
    assign q400  = ({8'd0, r_q} << 8) + ({8'd0, r_q} << 7) + ({8'd0, r_q} << 4);
    assign o_rem = 9'(r_yr - q400);

endmodule

[rtl/gdad_step.sv]
// Shared month step: compare day count to month length, subtract, advance month.
module gdad_step import gdad_pkg::*; (
    input  logic [15:0] i_nd,
    input  logic [3:0]  i_month,
    input  logic        i_leap,
    output t_step       o_step
);

    logic [4:0] len;

    assign len = month_len(i_month, i_leap);

    // One compare and one subtract per cycle
    always_comb begin
        o_step.fits       = (i_nd <= {11'd0, len});
        o_step.nd_next    = i_nd - {11'd0, len};
        o_step.wrap       = (i_month == MONTH_DEC);
        o_step.month_next = o_step.wrap ? MONTH_JAN : i_month + 4'd1;
    end

endmodule

[rtl/gdad_chk.sv]
// Port-level checker for the date adder, bound to the top level.
`include "gregorian_date_add_days_defines.svh"

module gdad_chk import gdad_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_done,
    input t_out i_res
);

    logic res_err;
    logic res_zero;
    logic res_date_ok;

    // Classify the word on the result ports
    assign res_err     = (i_res.error_code != ERR_OK);
    assign res_zero    = (i_res.result_year == 16'd0) && (i_res.result_month == 4'd0) &&
                         (i_res.result_day == 5'd0);
    assign res_date_ok = (i_res.result_month >= MONTH_JAN) &&
                         (i_res.result_month <= MONTH_DEC) && (i_res.result_day != 5'd0);

    `GDAD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    `GDAD_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, i_done, !i_busy)
    `GDAD_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, i_done, !i_done)
    `GDAD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_done && res_err, res_zero)
    `GDAD_ASSERT_NOW(a_ok_date, i_clk, i_rst_n, i_done && !res_err, res_date_ok)

endmodule

bind gregorian_date_add_days gdad_chk u_gdad_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_done  (o_done),
    .i_res   (o_res)
);
